/* design/dkcp_pkg.sv */
// ----------------------------------------------------------------------------
// dkcp_pkg
// Shared types and constants of the debounced keypad with chord paging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dkcp_pkg;

  localparam int unsigned BUTTONS   = 8;
  localparam int unsigned IDX_W     = $clog2(BUTTONS);
  localparam int unsigned LOCK_W    = 16;
  localparam int unsigned CNT_W     = LOCK_W + 1;
  localparam int unsigned PAGE_W    = 4;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned LED_W     = 3;
  localparam int unsigned HUE_W     = 8;

  localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'd50;

  // Chord pairs: the first pair pages down, the second pages up.
  localparam logic [IDX_W-1:0] DN_A = 3'd0;
  localparam logic [IDX_W-1:0] DN_B = 3'd4;
  localparam logic [IDX_W-1:0] UP_A = 3'd3;
  localparam logic [IDX_W-1:0] UP_B = 3'd7;

  localparam logic [PAGE_W-1:0] PAGE_MIN   = 4'd1;
  localparam logic [PAGE_W-1:0] PAGE_MAX   = 4'd8;
  localparam logic [PAGE_W-1:0] PAGE_RESET = 4'd1;
  localparam logic [PAGE_W-1:0] SHOWN_RESET = 4'd0;

  // Hue of each indicator LED.
  localparam logic [HUE_W-1:0] LED_HUE [BUTTONS] = '{
    8'd0, 8'd32, 8'd64, 8'd96, 8'd128, 8'd160, 8'd192, 8'd224
  };

  typedef enum logic {
    KIND_KEY  = 1'b0,
    KIND_PAGE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [PAGE_W-1:0] page;
    logic [KEY_W-1:0]  key;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

/* design/dkcp_lane.sv */
// ----------------------------------------------------------------------------
// dkcp_lane
// One button: stored level, lockout counter and accepted-press detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dkcp_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_i,
  input  wire logic                        level_i,
  input  wire logic [dkcp_pkg::LOCK_W-1:0] lockout_i,
  output logic                             press_o
);

  logic [dkcp_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_dec;
  logic                       prev_q;
  logic                       accept;

  // The counter first runs down by one on every tick, then may be reloaded.
  assign cnt_dec = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
  assign accept  = (level_i != prev_q) && (cnt_dec == '0);
  assign press_o = accept && !level_i;
  assign cnt_d   = accept ? ({1'b0, lockout_i} + 1'b1) : cnt_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= 1'b1;
    end else if (tick_i) begin
      cnt_q  <= cnt_d;
      prev_q <= level_i;
    end
  end

endmodule

`default_nettype wire

/* design/dkcp_merge.sv */
// ----------------------------------------------------------------------------
// dkcp_merge
// Walks the lane results in button order, applies chords to the page and
// emits key events and the page update through a pending and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dkcp_merge (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [dkcp_pkg::BUTTONS-1:0] press_i,
  input  wire logic [dkcp_pkg::BUTTONS-1:0] levels_i,
  output logic                              idle_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output dkcp_pkg::res_t                    out_res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_LAST
  } state_e;

  state_e                          state_q;
  logic [dkcp_pkg::IDX_W-1:0]      idx_q;
  logic [dkcp_pkg::BUTTONS-1:0]    press_q;
  logic [dkcp_pkg::BUTTONS-1:0]    lv_q;
  logic [dkcp_pkg::PAGE_W-1:0]     page_q;
  logic [dkcp_pkg::PAGE_W-1:0]     shown_q;
  logic                            pend_vld_q;
  dkcp_pkg::res_t                  pend_q;
  logic                            out_vld_q;
  dkcp_pkg::res_t                  out_q;

  logic           can_push;
  logic           cur_press;
  logic           is_dn;
  logic           is_up;
  logic           is_key;
  logic           scan_go;
  logic           push;
  dkcp_pkg::res_t push_res;
  dkcp_pkg::res_t key_res;
  dkcp_pkg::res_t upd_res;

  always_comb begin
    can_push  = !out_vld_q || out_ready_i;
    cur_press = press_q[idx_q];
    is_dn = cur_press &&
            (((idx_q == dkcp_pkg::DN_A) && !lv_q[dkcp_pkg::DN_B]) ||
             ((idx_q == dkcp_pkg::DN_B) && !lv_q[dkcp_pkg::DN_A]));
    is_up = cur_press &&
            (((idx_q == dkcp_pkg::UP_A) && !lv_q[dkcp_pkg::UP_B]) ||
             ((idx_q == dkcp_pkg::UP_B) && !lv_q[dkcp_pkg::UP_A]));
    is_key = cur_press && !is_dn && !is_up;

    key_res.kind = dkcp_pkg::KIND_KEY;
    key_res.page = page_q;
    key_res.key  = {{(dkcp_pkg::KEY_W - dkcp_pkg::IDX_W){1'b0}}, idx_q} + 1'b1;
    key_res.last = 1'b0;

    upd_res.kind = dkcp_pkg::KIND_PAGE;
    upd_res.page = page_q;
    upd_res.key  = '0;
    upd_res.last = 1'b0;

    // A key event must first move the previous one out of the way.
    scan_go  = !(is_key && pend_vld_q && !can_push);
    push     = 1'b0;
    push_res = pend_q;
    unique case (state_q)
      S_SCAN: begin
        push = scan_go && is_key && pend_vld_q;
      end
      S_FLUSH: begin
        push = (page_q != shown_q) && pend_vld_q && can_push;
      end
      S_LAST: begin
        push          = pend_vld_q && can_push;
        push_res.last = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      press_q    <= '0;
      lv_q       <= '1;
      page_q     <= dkcp_pkg::PAGE_RESET;
      shown_q    <= dkcp_pkg::SHOWN_RESET;
      pend_vld_q <= 1'b0;
      pend_q     <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (push) begin
        out_q     <= push_res;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            press_q <= press_i;
            lv_q    <= levels_i;
            idx_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            if (is_key) begin
              pend_q     <= key_res;
              pend_vld_q <= 1'b1;
            end
            if (is_dn && (page_q > dkcp_pkg::PAGE_MIN)) begin
              page_q <= page_q - 1'b1;
            end
            if (is_up && (page_q < dkcp_pkg::PAGE_MAX)) begin
              page_q <= page_q + 1'b1;
            end
            if (idx_q == dkcp_pkg::IDX_W'(dkcp_pkg::BUTTONS - 1)) begin
              state_q <= S_FLUSH;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (page_q != shown_q) begin
            if (!(pend_vld_q && !can_push)) begin
              pend_q     <= upd_res;
              pend_vld_q <= 1'b1;
              shown_q    <= page_q;
              state_q    <= S_LAST;
            end
          end else begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          if (pend_vld_q) begin
            if (can_push) begin
              pend_vld_q <= 1'b0;
              state_q    <= S_IDLE;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

/* design/debounced_keypad_with_chord_paging.sv */
// ----------------------------------------------------------------------------
// debounced_keypad_with_chord_paging
// Eight-button debounce with per-button lockout, chord paging and a page
// indicator update, one input transfer per tick.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------------
//   in       input      in_valid_i / in_ready_o   in_levels_i
//   out      output     out_valid_o / out_ready_i kind, page, key, led_index,
//                                                 led_hue, last
//   cfg      input      cfg_we_i (no wait)        cfg_data_i (lockout ticks)
//
// On an input transfer the merge sequencer captures the presses and levels,
// then visits the buttons in order (S_SCAN), checks the page (S_FLUSH) and
// hands over the final result (S_LAST); in_ready_o returns when it is idle.
// The button-order walk in the merge stage sets the pace of ticks. Output
// stalls hold the sequence only where a result must move out.
// Reset (rst_ni low, asynchronous) releases all buttons, clears the lockouts,
// sets page 1 and forces a page update on the first tick.
//
`timescale 1ns / 1ps
`default_nettype none

module debounced_keypad_with_chord_paging (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dkcp_pkg::LOCK_W-1:0]        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [dkcp_pkg::BUTTONS-1:0]       in_levels_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    out_kind_o,
  output logic [dkcp_pkg::PAGE_W-1:0]             out_page_o,
  output logic [dkcp_pkg::KEY_W-1:0]              out_key_o,
  output logic [dkcp_pkg::LED_W-1:0]              out_led_index_o,
  output logic [dkcp_pkg::HUE_W-1:0]              out_led_hue_o,
  output logic                                    out_last_o
);

  // Lockout length register, written directly from the configuration port.
  logic [dkcp_pkg::LOCK_W-1:0]  lockout_q;
  logic                         tick;
  logic                         idle;
  logic [dkcp_pkg::BUTTONS-1:0] press;
  dkcp_pkg::res_t               res;
  logic [dkcp_pkg::LED_W-1:0]   led_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= dkcp_pkg::LOCKOUT_RESET;
    end else if (cfg_we_i) begin
      lockout_q <= cfg_data_i;
    end
  end

  // A new tick is taken only while the sequencer is idle; all lanes update
  // their counters and stored levels in the cycle of that transfer.
  assign in_ready_o = idle;
  assign tick       = in_valid_i && in_ready_o;

  for (genvar g = 0; g < dkcp_pkg::BUTTONS; g++) begin : g_lane
    dkcp_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tick_i    (tick),
      .level_i   (in_levels_i[g]),
      .lockout_i (lockout_q),
      .press_o   (press[g])
    );
  end

  // The merge stage walks the accepted presses in button order so that
  // chords and key events see the page exactly as it stands at each button.
  dkcp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (tick),
    .press_i     (press),
    .levels_i    (in_levels_i),
    .idle_o      (idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  // LED fields are derived from the registered page; zero on key events.
  assign led_idx         = (res.kind == dkcp_pkg::KIND_PAGE) ?
                           dkcp_pkg::LED_W'(res.page - 1'b1) : '0;
  assign out_kind_o      = res.kind;
  assign out_page_o      = res.page;
  assign out_key_o       = res.key;
  assign out_led_index_o = led_idx;
  assign out_led_hue_o   = (res.kind == dkcp_pkg::KIND_PAGE) ?
                           dkcp_pkg::LED_HUE[led_idx] : '0;
  assign out_last_o      = res.last;

  // A tick transfer always starts a busy period.
  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> !in_ready_o)
    else $error("input ready stayed high after a tick transfer");

  // The page update is always the final result of its tick.
  a_page_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o |-> out_last_o && (out_key_o == '0))
    else $error("page update not marked last or carries a key");

  // Key events carry a valid key number.
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_kind_o |-> (out_key_o != '0) && (out_key_o <= 4'd8))
    else $error("key event with key number out of range");

  // The reported page stays within its limits.
  a_page_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_page_o >= dkcp_pkg::PAGE_MIN) &&
                    (out_page_o <= dkcp_pkg::PAGE_MAX))
    else $error("page out of range");

endmodule

`default_nettype wire

/* bench/dkcp_event_checker.sv */
// ----------------------------------------------------------------------------
// dkcp_event_checker
// Watches the tick, result and lockout register ports of the keypad, keeps
// its own model of the debounce, chord paging and page indicator state, and
// compares every result transfer with the oldest predicted event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dkcp_event_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dkcp_pkg::LOCK_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [dkcp_pkg::BUTTONS-1:0]   in_levels_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           out_kind_i,
  input  logic [dkcp_pkg::PAGE_W-1:0]    out_page_i,
  input  logic [dkcp_pkg::KEY_W-1:0]     out_key_i,
  input  logic [dkcp_pkg::LED_W-1:0]     out_led_index_i,
  input  logic [dkcp_pkg::HUE_W-1:0]     out_led_hue_i,
  input  logic                           out_last_i,
  output int unsigned                    errors_o,
  output int unsigned                    pending_o
);

  typedef struct packed {
    dkcp_pkg::kind_e             kind;
    logic [dkcp_pkg::PAGE_W-1:0] page;
    logic [dkcp_pkg::KEY_W-1:0]  key;
    logic [dkcp_pkg::LED_W-1:0]  led_index;
    logic [dkcp_pkg::HUE_W-1:0]  led_hue;
    logic                        last;
  } keypad_event_t;

  logic [dkcp_pkg::LOCK_W-1:0]  lockout_ticks;
  logic [dkcp_pkg::BUTTONS-1:0] held_levels;
  logic [dkcp_pkg::CNT_W-1:0]   lock_left [dkcp_pkg::BUTTONS];
  logic [dkcp_pkg::PAGE_W-1:0]  page_now;
  logic [dkcp_pkg::PAGE_W-1:0]  page_shown;
  keypad_event_t                expected_events [$];
  int unsigned                  errors;

  // Works out the events of one tick and queues them in order.
  task automatic predict_tick(input logic [dkcp_pkg::BUTTONS-1:0] lv);
    keypad_event_t tick_events [$];
    keypad_event_t ev;
    logic [dkcp_pkg::LED_W-1:0] led;
    int b;
    for (b = 0; b < dkcp_pkg::BUTTONS; b++) begin
      if (lock_left[b] != '0) lock_left[b] = lock_left[b] - 1'b1;
    end
    for (b = 0; b < dkcp_pkg::BUTTONS; b++) begin
      if (lv[b] == held_levels[b]) continue;
      if (lock_left[b] == '0) begin
        if (!lv[b]) begin
          if ((b == dkcp_pkg::DN_A && !lv[dkcp_pkg::DN_B]) ||
              (b == dkcp_pkg::DN_B && !lv[dkcp_pkg::DN_A])) begin
            if (page_now > dkcp_pkg::PAGE_MIN) page_now = page_now - 1'b1;
          end else if ((b == dkcp_pkg::UP_A && !lv[dkcp_pkg::UP_B]) ||
                       (b == dkcp_pkg::UP_B && !lv[dkcp_pkg::UP_A])) begin
            if (page_now < dkcp_pkg::PAGE_MAX) page_now = page_now + 1'b1;
          end else begin
            ev           = '0;
            ev.kind      = dkcp_pkg::KIND_KEY;
            ev.page      = page_now;
            ev.key       = dkcp_pkg::KEY_W'(b + 1);
            tick_events.push_back(ev);
          end
        end
        lock_left[b] = {1'b0, lockout_ticks} + dkcp_pkg::CNT_W'(1);
      end
      held_levels[b] = lv[b];
    end
    if (page_now != page_shown) begin
      led          = dkcp_pkg::LED_W'(page_now - 1'b1);
      ev           = '0;
      ev.kind      = dkcp_pkg::KIND_PAGE;
      ev.page      = page_now;
      ev.led_index = led;
      ev.led_hue   = {led, 5'd0};
      tick_events.push_back(ev);
      page_shown   = page_now;
    end
    for (b = 0; b < tick_events.size(); b++) begin
      ev      = tick_events[b];
      ev.last = (b == tick_events.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  function automatic bit field_bad(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_result();
    keypad_event_t want;
    bit bad;
    if (expected_events.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected result kind %0d page %0d key %0d led %0d hue %0d last %0d",
               $time, out_kind_i, out_page_i, out_key_i, out_led_index_i, out_led_hue_i,
               out_last_i);
    end else begin
      want = expected_events.pop_front();
      bad = field_bad("kind", want.kind, out_kind_i)
          | field_bad("page", want.page, out_page_i)
          | field_bad("key", want.key, out_key_i)
          | field_bad("led_index", want.led_index, out_led_index_i)
          | field_bad("led_hue", want.led_hue, out_led_hue_i)
          | field_bad("last", want.last, out_last_i);
      if (bad) errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ticks = dkcp_pkg::LOCKOUT_RESET;
      held_levels   = '1;
      lock_left     = '{default: '0};
      page_now      = dkcp_pkg::PAGE_RESET;
      page_shown    = dkcp_pkg::SHOWN_RESET;
      errors        = 0;
      expected_events.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) lockout_ticks = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_tick(in_levels_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o <= expected_events.size();
      errors_o  <= errors;
    end
  end

endmodule

/* bench/debounced_keypad_with_chord_paging_test.sv */
// ----------------------------------------------------------------------------
// debounced_keypad_with_chord_paging_test
// Drives ticks of button levels into the keypad under several lockout
// settings, with random idling on both channels, and lets the event checker
// judge every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_keypad_with_chord_paging_test;

  // A tick can be held off by a sender gap before it and by an output stall on
  // each of its results. A few hundred ticks fit well inside this limit.
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  // A tick that causes no result still keeps the block busy while the sequencer
  // walks the buttons. This pause covers it before a register write and at the end of the run.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PRE_CONFIG    = 4;

  // The first four ticks run with the reset lockout of 50: the first tick
  // shows page 1, button 6 is pressed, and its release and second press fall
  // inside the lockout. The rest run with a lockout of zero: presses of 3 and
  // 7 together page up twice per tick until the page saturates at 8 and a tick
  // causes no result at all, presses of 0 and 4 page down to 1, all buttons go
  // down at once, and a chord and a key press share one tick.
  localparam logic [dkcp_pkg::BUTTONS-1:0] DIRECTED_TICKS [25] = '{
    8'hFF, 8'hBF, 8'hFF, 8'hBF,
    8'hFF, 8'h77, 8'hFF, 8'h77, 8'hFF, 8'h77, 8'hFF, 8'h77, 8'hFF, 8'h77,
    8'hEE, 8'hFF, 8'hEE, 8'hFF, 8'hEE, 8'hFF, 8'hEE,
    8'hFF, 8'h00, 8'hFF, 8'h57
  };

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [dkcp_pkg::LOCK_W-1:0]   cfg_data_i      = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_ready_o;
  logic [dkcp_pkg::BUTTONS-1:0]  in_levels_i     = '1;
  logic                          out_valid_o;
  logic                          out_ready_i     = 1'b0;
  logic                          out_kind_o;
  logic [dkcp_pkg::PAGE_W-1:0]   out_page_o;
  logic [dkcp_pkg::KEY_W-1:0]    out_key_o;
  logic [dkcp_pkg::LED_W-1:0]    out_led_index_o;
  logic [dkcp_pkg::HUE_W-1:0]    out_led_hue_o;
  logic                          out_last_o;

  int unsigned                   errors;
  int unsigned                   pending;
  int unsigned                   stall_left      = 0;
  int unsigned                   cycle_count     = 0;
  // When set, neither side idles any more.
  logic                          quiet           = 1'b0;
  logic [dkcp_pkg::BUTTONS-1:0]  levels_now      = '1;

  debounced_keypad_with_chord_paging dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_levels_i     (in_levels_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_kind_o      (out_kind_o),
    .out_page_o      (out_page_o),
    .out_key_o       (out_key_o),
    .out_led_index_o (out_led_index_o),
    .out_led_hue_o   (out_led_hue_o),
    .out_last_o      (out_last_o)
  );

  dkcp_event_checker event_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_levels_i     (in_levels_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_kind_i      (out_kind_o),
    .out_page_i      (out_page_o),
    .out_key_i       (out_key_o),
    .out_led_index_i (out_led_index_o),
    .out_led_hue_i   (out_led_hue_o),
    .out_last_i      (out_last_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls in random bursts now and then, so that stalls land
  // on every result position of a tick.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left  <= $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Presents one tick and returns in the time step of its transfer. Valid is
  // left high, so a back-to-back tick only updates the levels; a gap lowers
  // valid first.
  task automatic send_tick(input logic [dkcp_pkg::BUTTONS-1:0] lv);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_levels_i <= lv;
    levels_now  = lv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops the tick stream, waits for every predicted event to come out and
  // then for the block to finish a tick that may have caused none.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lockout(input logic [dkcp_pkg::LOCK_W-1:0] ticks);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One random phase under a fresh lockout setting. The largest share of ticks
  // toggle one or two buttons, as a real keypad does, so that presses pass the
  // debounce and reach the chord logic; chords are forced now and then, and the
  // rest are full releases, unchanged levels that let lockouts run out, and noise.
  task automatic run_phase(input logic [dkcp_pkg::LOCK_W-1:0] ticks, input int count);
    logic [dkcp_pkg::BUTTONS-1:0] lv;
    settle();
    write_lockout(ticks);
    repeat (count) begin
      lv = levels_now;
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4: lv = lv ^ (dkcp_pkg::BUTTONS'(1) <<
                                  $urandom_range(0, dkcp_pkg::BUTTONS - 1));
        5: lv = lv ^ (dkcp_pkg::BUTTONS'(1) << $urandom_range(0, dkcp_pkg::BUTTONS - 1))
                   ^ (dkcp_pkg::BUTTONS'(1) << $urandom_range(0, dkcp_pkg::BUTTONS - 1));
        6: lv = lv & ~((dkcp_pkg::BUTTONS'(1) << dkcp_pkg::UP_A) |
                       (dkcp_pkg::BUTTONS'(1) << dkcp_pkg::UP_B));
        7: lv = lv & ~((dkcp_pkg::BUTTONS'(1) << dkcp_pkg::DN_A) |
                       (dkcp_pkg::BUTTONS'(1) << dkcp_pkg::DN_B));
        8: lv = '1;
        9: lv = dkcp_pkg::BUTTONS'($urandom_range(0, 255));
        default: lv = levels_now;
      endcase
      send_tick(lv);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks: the first few under the reset lockout, the rest with
    // no lockout at all.
    for (int k = 0; k < PRE_CONFIG; k++) send_tick(DIRECTED_TICKS[k]);
    settle();
    write_lockout('0);
    for (int k = PRE_CONFIG; k < 25; k++) send_tick(DIRECTED_TICKS[k]);

    // Random ticks under several lockouts. The largest lockout freezes every
    // button after its first change, so it comes last; the final phases run
    // with no idling on either side.
    run_phase(dkcp_pkg::LOCK_W'(1), 55);
    run_phase('0, 55);
    run_phase(dkcp_pkg::LOCK_W'($urandom_range(2, 12)), 55);
    quiet <= 1'b1;
    run_phase(dkcp_pkg::LOCK_W'(2), 55);
    run_phase('1, 12);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a handshake that never completes ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* debounced_keypad_with_chord_paging.f */
design/dkcp_pkg.sv
design/dkcp_lane.sv
design/dkcp_merge.sv
design/debounced_keypad_with_chord_paging.sv
bench/dkcp_event_checker.sv
bench/debounced_keypad_with_chord_paging_test.sv
